/* hw/rtl/ctwl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Credential table package
// Shared widths, request codes, controller/datapath handshake types and the
// power-on contents of the five built-in user entries.
// ----------------------------------------------------------------------------
package ctwl_pkg;

  localparam int DEF_ENTRIES  = 16;
  localparam int ID_W         = 32;
  localparam int PIN_W        = 32;
  localparam int STRIKE_W     = 2;
  localparam int REQ_W        = 4;
  localparam int NUM_DEFAULTS = 5;

  localparam logic [STRIKE_W-1:0] MAX_STRIKES = STRIKE_W'(3);

  localparam logic [ID_W-1:0]  ADMIN_ID    = ID_W'(15);
  localparam logic [PIN_W-1:0] ADMIN_PIN   = PIN_W'(12345);
  localparam logic [PIN_W-1:0] COMMON_PIN  = PIN_W'(1234);

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD     = 4'd0,
    REQ_DELETE  = 4'd1,
    REQ_STRIKE  = 4'd2,
    REQ_CLEAR   = 4'd3,
    REQ_ADMIN   = 4'd4,
    REQ_BLOCKED = 4'd5,
    REQ_EXISTS  = 4'd6,
    REQ_CHECK   = 4'd7,
    REQ_SET_PIN = 4'd8
  } req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic scan;
    logic exec;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
  } sts_t;

  // Built-in id of entry idx; entries beyond the defaults start at zero.
  function automatic logic [ID_W-1:0] default_id(input logic [31:0] idx);
    logic [ID_W-1:0] val;
    val = '0;
    if (idx == 32'd0) begin
      val = ADMIN_ID;
    end else if (idx < 32'(NUM_DEFAULTS)) begin
      val = ID_W'(idx);
    end
    return val;
  endfunction

  // Built-in PIN of entry idx.
  function automatic logic [PIN_W-1:0] default_pin(input logic [31:0] idx);
    logic [PIN_W-1:0] val;
    val = '0;
    if (idx == 32'd0) begin
      val = ADMIN_PIN;
    end else if (idx < 32'(NUM_DEFAULTS)) begin
      val = COMMON_PIN;
    end
    return val;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ctwl_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Credential table datapath
// Id and PIN memories with registered reads, per-entry flag registers, the
// lookup compare stage and the request execution and result registers.
// ----------------------------------------------------------------------------
module ctwl_datapath
  import ctwl_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  input  wire logic [REQ_W-1:0] in_req,
  input  wire logic [ID_W-1:0]  in_uid,
  input  wire logic [PIN_W-1:0] in_pin,
  input  wire logic             in_avail,
  input  wire logic             in_admin,
  input  wire logic             in_blocked,
  input  wire logic [STRIKE_W-1:0] in_strikes,
  output logic                  res_matched,
  output logic                  res_answer,
  output logic                  res_written
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // Latched request
  logic [REQ_W-1:0]    req;
  logic [ID_W-1:0]     uid;
  logic [PIN_W-1:0]    req_pin;
  logic                n_avail;
  logic                n_admin;
  logic                n_blocked;
  logic [STRIKE_W-1:0] n_strikes;

  // Table storage
  logic [ID_W-1:0]     id_mem  [ENTRIES];
  logic [PIN_W-1:0]    pin_mem [ENTRIES];
  logic [ENTRIES-1:0]  id_wr;
  logic [ENTRIES-1:0]  pin_wr;
  logic [ENTRIES-1:0]  in_use;
  logic [ENTRIES-1:0]  admin;
  logic [ENTRIES-1:0]  blocked;
  logic [STRIKE_W-1:0] strikes [ENTRIES];

  // Scan and compare stage
  logic [IW-1:0]       scan_idx;
  logic [IW-1:0]       q_idx;
  logic                q_valid;
  logic [ID_W-1:0]     id_rd;
  logic [PIN_W-1:0]    pin_rd;
  logic                id_v_q;
  logic                pin_v_q;

  // Lookup outcome
  logic                hit;
  logic [IW-1:0]       hit_idx;
  logic [PIN_W-1:0]    hit_pin;
  logic                free_found;
  logic [IW-1:0]       free_idx;

  logic [ID_W-1:0]     id_cur;
  logic [PIN_W-1:0]    pin_cur;
  logic                match_now;
  logic                free_now;
  logic                need_lookup;
  logic [IW-1:0]       slot;
  logic                do_add;
  logic                do_set_pin;
  logic                do_delete;
  logic                do_strike;
  logic                do_clear;
  logic [STRIKE_W-1:0] strike_next;
  logic                answer_c;

  always_comb begin
    id_cur      = id_v_q  ? id_rd  : default_id(32'(q_idx));
    pin_cur     = pin_v_q ? pin_rd : default_pin(32'(q_idx));
    match_now   = q_valid && (id_cur == uid);
    free_now    = q_valid && !in_use[q_idx];
    need_lookup = req inside {REQ_ADD, REQ_DELETE, REQ_STRIKE, REQ_ADMIN, REQ_BLOCKED,
                              REQ_EXISTS, REQ_CHECK, REQ_SET_PIN};
    sts.done    = !need_lookup || match_now || (q_valid && (q_idx == LAST_IDX));

    slot        = hit ? hit_idx : free_idx;
    do_add      = cmd.exec && (req == REQ_ADD) && (hit || free_found);
    do_set_pin  = cmd.exec && (req == REQ_SET_PIN) && hit;
    do_delete   = cmd.exec && (req == REQ_DELETE) && hit;
    do_strike   = cmd.exec && (req == REQ_STRIKE) && hit;
    do_clear    = cmd.exec && (req == REQ_CLEAR);

    if (strikes[hit_idx] == MAX_STRIKES) begin
      strike_next = MAX_STRIKES;
    end else begin
      strike_next = strikes[hit_idx] + 1'b1;
    end

    case (req)
      REQ_ADMIN:   answer_c = hit && admin[hit_idx];
      REQ_BLOCKED: answer_c = hit && blocked[hit_idx];
      REQ_EXISTS:  answer_c = hit && in_use[hit_idx];
      REQ_CHECK:   answer_c = hit && in_use[hit_idx] && (hit_pin == req_pin);
      default:     answer_c = 1'b0;
    endcase
  end

  // Memories: one registered read at the scan address, one write port.
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      id_rd  <= id_mem[scan_idx];
      pin_rd <= pin_mem[scan_idx];
    end
    if (do_add) begin
      id_mem[slot] <= uid;
    end
    if (do_add || do_set_pin) begin
      pin_mem[slot] <= req_pin;
    end
  end

  // Control state and per-entry flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      q_valid    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      id_wr      <= '0;
      pin_wr     <= '0;
      for (int k = 0; k < ENTRIES; k++) begin
        in_use[k]  <= (k < NUM_DEFAULTS);
        admin[k]   <= (k == 0);
        blocked[k] <= 1'b0;
        strikes[k] <= '0;
      end
    end else begin
      q_valid <= cmd.scan;
      if (cmd.start) begin
        scan_idx   <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (cmd.scan) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (match_now) begin
          hit <= 1'b1;
        end
        if (free_now) begin
          free_found <= 1'b1;
        end
      end

      if (do_add) begin
        id_wr[slot]   <= 1'b1;
        pin_wr[slot]  <= 1'b1;
        in_use[slot]  <= n_avail;
        admin[slot]   <= n_admin;
        blocked[slot] <= n_blocked;
        strikes[slot] <= n_strikes;
      end
      if (do_set_pin) begin
        pin_wr[hit_idx] <= 1'b1;
      end
      if (do_delete) begin
        in_use[hit_idx] <= 1'b0;
      end
      if (do_strike) begin
        strikes[hit_idx] <= strike_next;
        if (strike_next == MAX_STRIKES) begin
          blocked[hit_idx] <= 1'b1;
        end
      end
      if (do_clear) begin
        for (int k = 0; k < ENTRIES; k++) begin
          strikes[k] <= '0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req       <= in_req;
      uid       <= in_uid;
      req_pin   <= in_pin;
      n_avail   <= in_avail;
      n_admin   <= in_admin;
      n_blocked <= in_blocked;
      n_strikes <= in_strikes;
    end
    if (cmd.scan) begin
      q_idx   <= scan_idx;
      id_v_q  <= id_wr[scan_idx];
      pin_v_q <= pin_wr[scan_idx];
    end
    if (match_now) begin
      hit_idx <= q_idx;
      hit_pin <= pin_cur;
    end
    if (free_now && !free_found) begin
      free_idx <= q_idx;
    end
    if (cmd.exec) begin
      res_matched <= hit;
      res_answer  <= answer_c;
      res_written <= do_add;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ctwl_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Credential table controller
// Sequences accept, table scan and execute, and owns the result word's
// valid flag on the output side.
// ----------------------------------------------------------------------------
module ctwl_ctrl
  import ctwl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  always_comb begin
    slot_free  = !out_valid || out_ready;
    in_ready   = (state == ST_IDLE);
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.done) begin
          state_next = ST_EXEC;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/credential_table_with_lockout_core.sv */
// Flow: a request passes through the scan and execute states from acceptance to
// its result word; clear strikes and unknown codes end the scan at once, and
// the id scan reads one table entry per cycle through the registered id/PIN
// memory read port. Requests: one at a time; the next word can be taken as soon
// as the previous result is loaded, even while it waits.
// Reset: synchronous, active high; restores the five built-in users at once.
`default_nettype none
// ----------------------------------------------------------------------------
// Credential table with strike lockout
// Top level: a table of user entries with add, delete, strike, clear, query
// and PIN requests over a streaming slave port, one result word per request.
// ----------------------------------------------------------------------------
module credential_table_with_lockout_core
  import ctwl_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // Request side
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [3:0] s_axis_tuser,   // [3:0] req_type
  // [31:0] user_id, [63:32] pin, [64] new_available, [65] new_admin,
  // [66] new_blocked, [68:67] new_strikes, [71:69] zero
  input  wire logic [71:0] s_axis_tdata,
  // Result side
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  // [0] matched, [1] answer, [2] written, [7:3] zero
  output logic [7:0]      m_axis_tdata
);

  // The controller walks through idle, scan and execute. During the scan the
  // datapath issues one memory read per cycle and compares the entry read in
  // the cycle before, so the first matching id and the first free entry are
  // both found in a single pass. Entries of the id and PIN memories that have
  // never been written read as their built-in values through per-entry
  // written bits, so no clearing pass follows reset.

  cmd_t cmd;
  sts_t sts;
  logic res_matched;
  logic res_answer;
  logic res_written;

  ctwl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ctwl_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_req      (s_axis_tuser),
    .in_uid      (s_axis_tdata[31:0]),
    .in_pin      (s_axis_tdata[63:32]),
    .in_avail    (s_axis_tdata[64]),
    .in_admin    (s_axis_tdata[65]),
    .in_blocked  (s_axis_tdata[66]),
    .in_strikes  (s_axis_tdata[68:67]),
    .res_matched (res_matched),
    .res_answer  (res_answer),
    .res_written (res_written)
  );

  // The unused upper bits of the request word are ignored by design.
  assign m_axis_tdata = {5'b00000, res_written, res_answer, res_matched};

endmodule
`default_nettype wire

/* hw/rtl/ctwl_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Credential table port checker
// Watches the top-level ports for result words that break the block's rules.
// ----------------------------------------------------------------------------
module ctwl_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  // A waiting result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result word changed or dropped while stalled");

  // Only one request is in the block: no new word the cycle after one is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  // A positive query answer needs a matching entry.
  a_answer_needs_match: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])
    else $error("answer set without a matching entry");

  // A query never stores, and padding bits stay zero.
  a_answer_or_write: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!(m_axis_tdata[1] && m_axis_tdata[2]) && m_axis_tdata[7:3] == 5'd0))
    else $error("malformed result word");

endmodule

bind credential_table_with_lockout_core ctwl_checker u_ctwl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
